>>> src/hgl_pkg.sv
// Shared types, constants and functions for the grid to latitude/longitude converter.
// Used by hgl_isqrt, hgl_cordic and hrap_grid_to_lat_lon; depends on nothing else.
package hgl_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 24;
	localparam int SQRT_STAGES  = 16;   // two root bits per stage, 32 root bits
	localparam int CW           = 46;   // CORDIC vector width
	localparam int ZW           = 34;   // CORDIC angle width, binary turns
	localparam int PW           = 48;   // degree conversion width

	localparam logic [12:0] POLE_COL = 13'd401;
	localparam logic [12:0] POLE_ROW = 13'd1601;
	localparam logic [63:0] G_RADICAND = 64'd623171529 << 30;

	localparam logic signed [PW-1:0] ROUND_FX   = PW'(1) <<< (31 - FRAC_BITS);
	localparam int                   DEG_SHIFT  = 32 - FRAC_BITS;
	localparam logic signed [PW-1:0] LON_BASE_FX = PW'(375) <<< FRAC_BITS;
	localparam logic signed [PW-1:0] FULL_FX    = PW'(360) <<< FRAC_BITS;
	localparam logic signed [PW-1:0] QUARTER_FX = PW'(90) <<< FRAC_BITS;

	// atan(2^-i) in binary turns, 2^32 per turn
	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic [35:0] rem;
		logic [31:0] root;
		logic [63:0] rad;
	} sqrt_state_t;

	// One root bit of the digit-by-digit square root
	function automatic sqrt_state_t sqrt_step(input sqrt_state_t s);
		logic [35:0] r;
		logic [35:0] trial;
		logic        ge;
		sqrt_state_t o;
		r       = {s.rem[33:0], s.rad[63:62]};
		trial   = {2'b00, s.root, 2'b01};
		ge      = (r >= trial);
		o.rem   = ge ? (r - trial) : r;
		o.root  = {s.root[30:0], ge};
		o.rad   = {s.rad[61:0], 2'b00};
		return o;
	endfunction

	// Elaboration-time square root for the fixed grid constant
	function automatic logic [31:0] isqrt64(input logic [63:0] v);
		sqrt_state_t s;
		s.rem  = '0;
		s.root = '0;
		s.rad  = v;
		for (int k = 0; k < 32; k++) begin
			s = sqrt_step(s);
		end
		return s.root;
	endfunction

	localparam logic [31:0] G_ROOT = isqrt64(G_RADICAND);

endpackage

>>> src/hrap_grid_to_lat_lon.sv
// Grid column/row to latitude and west longitude on the polar stereographic grid.
// One request per cycle while no result waits untaken at the output.
// The square root stages followed by the CORDIC stages, between the input and output stages, set the depth.
// The whole pipeline stalls together while a result waits at the output.
// Reset clears the valid bits only; depends on hgl_pkg, hgl_isqrt, hgl_cordic.
module hrap_grid_to_lat_lon import hgl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // grid_col[11:0], grid_row[23:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // latitude[23:0], longitude[48:24], zero fill
);

	localparam int DEPTH = SQRT_STAGES + CORDIC_STEPS + 4;

	logic             adv;
	logic [DEPTH-1:0] vld_q;

	// Stall the whole pipeline only while the output holds an untaken result
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	// Stage 1: move the pole, square radius
	logic signed [12:0] x_c, y_c;
	logic signed [25:0] xx_c, yy_c;
	logic signed [12:0] x_s1, y_s1;
	logic [24:0]        r2_s1;

	assign x_c  = $signed({1'b0, s_tdata[11:0]}) - $signed(POLE_COL);
	assign y_c  = $signed({1'b0, s_tdata[23:12]}) - $signed(POLE_ROW);
	assign xx_c = 26'(x_c) * 26'(x_c);
	assign yy_c = 26'(y_c) * 26'(y_c);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1  <= x_c;
			y_s1  <= y_c;
			r2_s1 <= xx_c[24:0] + yy_c[24:0];
		end
	end

	// Stage 2: scale r2, fold the longitude vector into the right half plane
	logic signed [CW-1:0] bx_c, by_c;
	logic [31:0]          a_s2;
	logic signed [CW-1:0] vx_s2, vy_s2;
	logic signed [ZW-1:0] vz_s2;
	logic                 vzero_s2;

	assign bx_c = CW'(x_s1) <<< 30;
	assign by_c = CW'(y_s1) <<< 30;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2     <= 32'(r2_s1) * 32'd100;
			vzero_s2 <= (y_s1 == '0);
			if (x_s1[12]) begin
				vx_s2 <= -bx_c;
				vy_s2 <= -by_c;
				vz_s2 <= ZW'(64'd1 << 31);
			end else begin
				vx_s2 <= bx_c;
				vy_s2 <= by_c;
				vz_s2 <= '0;
			end
		end
	end

	// Radius square root
	logic [31:0] rad;

	hgl_isqrt u_isqrt (
		.clk  (clk),
		.en   (adv),
		.a    (a_s2),
		.root (rad)
	);

	// Hold the longitude vector alongside the square root stages
	logic signed [CW-1:0] dvx_s [SQRT_STAGES+1];
	logic signed [CW-1:0] dvy_s [SQRT_STAGES+1];
	logic signed [ZW-1:0] dvz_s [SQRT_STAGES+1];
	logic                 dvzero_s [SQRT_STAGES+1];

	assign dvx_s[0]    = vx_s2;
	assign dvy_s[0]    = vy_s2;
	assign dvz_s[0]    = vz_s2;
	assign dvzero_s[0] = vzero_s2;

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_delay
		always_ff @(posedge clk) begin
			if (adv) begin
				dvx_s[i+1]    <= dvx_s[i];
				dvy_s[i+1]    <= dvy_s[i];
				dvz_s[i+1]    <= dvz_s[i];
				dvzero_s[i+1] <= dvzero_s[i];
			end
		end
	end

	// Half colatitude and polar angle, side by side
	logic signed [ZW-1:0] half_colat, polar;

	hgl_cordic u_cordic_lat (
		.clk     (clk),
		.en      (adv),
		.x_in    (CW'(G_ROOT)),
		.y_in    (CW'(rad)),
		.z_in    ('0),
		.zero_in (rad == '0),
		.z_out   (half_colat)
	);

	hgl_cordic u_cordic_lon (
		.clk     (clk),
		.en      (adv),
		.x_in    (dvx_s[SQRT_STAGES]),
		.y_in    (dvy_s[SQRT_STAGES]),
		.z_in    (dvz_s[SQRT_STAGES]),
		.zero_in (dvzero_s[SQRT_STAGES]),
		.z_out   (polar)
	);

	// Stage 3: turns times 360 plus rounding
	logic signed [PW-1:0] lat_t_c;
	logic signed [PW-1:0] lat_prod_s3, lon_prod_s3;

	assign lat_t_c = (PW'(1) <<< 30) - (PW'(half_colat) <<< 1);

	always_ff @(posedge clk) begin
		if (adv) begin
			lat_prod_s3 <= lat_t_c * PW'(360) + ROUND_FX;
			lon_prod_s3 <= $signed({16'b0, polar[31:0]}) * PW'(360) + ROUND_FX;
		end
	end

	// Stage 4: scale to degrees, wrap longitude above a full circle
	logic signed [PW-1:0] lat_deg_c, lon_deg_c, lon_c;
	logic [23:0]          latitude_s4;
	logic [24:0]          longitude_s4;

	assign lat_deg_c = lat_prod_s3 >>> DEG_SHIFT;
	assign lon_deg_c = lon_prod_s3 >>> DEG_SHIFT;

	always_comb begin
		lon_c = LON_BASE_FX - lon_deg_c;
		if (lon_c > FULL_FX) begin
			lon_c = lon_c - FULL_FX;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			latitude_s4  <= lat_deg_c[23:0];
			longitude_s4 <= lon_c[24:0];
		end
	end

	assign m_tdata = {7'b0, longitude_s4, latitude_s4};

	// Checks
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_lon_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (FULL_FX < (PW'(1) <<< 25))) |-> (PW'(longitude_s4) <= FULL_FX))
		else $error("longitude beyond a full circle");

	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (QUARTER_FX < (PW'(1) <<< 23))) |->
		((PW'($signed(latitude_s4)) <= QUARTER_FX) &&
		 (PW'($signed(latitude_s4)) >= -QUARTER_FX)))
		else $error("latitude beyond a pole");

endmodule

>>> src/hgl_isqrt.sv
// Pipelined integer square root of r2*100*2^30, two root bits per stage.
// Depends on hgl_pkg.
module hgl_isqrt import hgl_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	output logic [31:0] root
);

	sqrt_state_t st_s [SQRT_STAGES+1];

	// Load the radicand with its 30 scale bits
	always_comb begin
		st_s[0].rem  = '0;
		st_s[0].root = '0;
		st_s[0].rad  = {2'b00, a, 30'b0};
	end

	// Advance two root bits a stage
	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[i+1] <= sqrt_step(sqrt_step(st_s[i]));
			end
		end
	end

	assign root = st_s[SQRT_STAGES].root;

endmodule

>>> src/hgl_cordic.sv
// Pipelined CORDIC in vectoring mode, one step per stage, angle in binary turns.
// Depends on hgl_pkg.
module hgl_cordic import hgl_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	input  logic                 zero_in,
	output logic signed [ZW-1:0] z_out
);

	logic signed [CW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [CW-1:0] y_s [CORDIC_STEPS+1];
	logic signed [ZW-1:0] z_s [CORDIC_STEPS+1];
	logic                 zero_s [CORDIC_STEPS+1];

	assign x_s[0]    = x_in;
	assign y_s[0]    = y_in;
	assign z_s[0]    = z_in;
	assign zero_s[0] = zero_in;

	// Rotate toward the x axis; a vector on the axis keeps its start angle
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= zero_s[i] ? z_s[i] : z_s[i] + ZW'(ATAN_TURNS[i]);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= zero_s[i] ? z_s[i] : z_s[i] - ZW'(ATAN_TURNS[i]);
				end
			end
		end
	end

	assign z_out = z_s[CORDIC_STEPS];

endmodule
